// ===== hw/rtl/multi_grain_substring_prefilter_core_defines.svh =====
// Assertion macros used by the prefilter top level.
`ifndef MULTI_GRAIN_SUBSTRING_PREFILTER_CORE_DEFINES_SVH
`define MULTI_GRAIN_SUBSTRING_PREFILTER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define MGSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prefilter check failed");
// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define MGSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prefilter check failed");
`else
`define MGSP_ASSERT_NOW(lbl, ante, cons)
`define MGSP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/mgsp_pkg.sv =====
// Types and constants of the multi-grain substring prefilter.
package mgsp_pkg;

  localparam int GRAIN_COUNT_MAX  = 16;
  localparam int GRAIN_LENGTH_MAX = 16;
  localparam int GRAIN_LENGTH_MIN = 2;

  // Fixed field widths of the words on the channels and config port.
  localparam int GI_FIELD_W = 4;
  localparam int CP_FIELD_W = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  // Internal widths that follow from the store geometry.
  localparam int GI_W   = $clog2(GRAIN_COUNT_MAX);
  localparam int CP_W   = $clog2(GRAIN_LENGTH_MAX);
  localparam int CNT_W  = $clog2(GRAIN_COUNT_MAX + 1);
  localparam int LEN_W  = $clog2(GRAIN_LENGTH_MAX + 1);
  // The byte counter saturates one above the longest grain, so that the
  // start-anchor window is seen exactly once even for the longest grain.
  localparam int SEEN_SAT = GRAIN_LENGTH_MAX + 1;
  localparam int SEEN_W   = $clog2(SEEN_SAT + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAIN_COUNT  = 2'd0,
    REG_GRAIN_LENGTH = 2'd1,
    REG_ANCHOR_START = 2'd2,
    REG_ANCHOR_END   = 2'd3
  } reg_idx_t;

  // Newest byte sits in entry 0.
  typedef logic [GRAIN_LENGTH_MAX-1:0][BYTE_W-1:0] window_t;

  // Clamped configuration seen by the compare array.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] length;
  } scan_cfg_t;

endpackage

// ===== hw/rtl/mgsp_in_if.sv =====
// Input channel: grain loads and text bytes.
interface mgsp_in_if;
  import mgsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [GI_FIELD_W-1:0] grain_index;
  logic [CP_FIELD_W-1:0] char_position;
  logic [BYTE_W-1:0]     byte_value;
  logic                  last_byte;

  modport source (output valid, operation, grain_index, char_position, byte_value,
                  last_byte, input ready);
  modport sink (input valid, operation, grain_index, char_position, byte_value,
                last_byte, output ready);
endinterface

// ===== hw/rtl/mgsp_out_if.sv =====
// Result channel: one verdict word per string.
interface mgsp_out_if;
  logic valid;
  logic ready;
  logic grain_found;

  modport source (output valid, grain_found, input ready);
  modport sink (input valid, grain_found, output ready);
endinterface

// ===== hw/rtl/mgsp_grain_store.sv =====
// Grain byte store with a parallel compare of every grain against the window.
module mgsp_grain_store (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [mgsp_pkg::GI_W-1:0] wr_grain,
  input  logic [mgsp_pkg::CP_W-1:0] wr_pos,
  input  logic [mgsp_pkg::BYTE_W-1:0] wr_byte,
  input  mgsp_pkg::window_t     window,
  input  mgsp_pkg::scan_cfg_t   scfg,
  output logic                  any_hit
);
  import mgsp_pkg::*;

  logic [BYTE_W-1:0] grain_r [GRAIN_COUNT_MAX][GRAIN_LENGTH_MAX];
  logic [BYTE_W-1:0] aligned [GRAIN_LENGTH_MAX];
  logic [GRAIN_LENGTH_MAX-1:0] pos_used;
  logic [GRAIN_COUNT_MAX-1:0]  grain_hit;

  // One byte written per load word; entries hold garbage until written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grain_r[wr_grain][wr_pos] <= wr_byte;
    end
  end

  // Grain byte d lines up with window entry length-1-d.
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int d = 0; d < GRAIN_LENGTH_MAX; d++) begin
      sel         = scfg.length - LEN_W'(1) - LEN_W'(d);
      aligned[d]  = window[sel[CP_W-1:0]];
      pos_used[d] = (LEN_W'(d) < scfg.length);
    end
  end

  // Every grain in use is compared over the active length.
  always_comb begin
    logic all_eq;
    for (int k = 0; k < GRAIN_COUNT_MAX; k++) begin
      all_eq = 1'b1;
      for (int d = 0; d < GRAIN_LENGTH_MAX; d++) begin
        if (pos_used[d] && (grain_r[k][d] != aligned[d])) begin
          all_eq = 1'b0;
        end
      end
      grain_hit[k] = all_eq && (CNT_W'(k) < scfg.count);
    end
  end

  assign any_hit = |grain_hit;

endmodule

// ===== hw/rtl/multi_grain_substring_prefilter_core.sv =====
// Top level of the multi-grain substring prefilter.
//
//  Channel  Direction  Handshake          Word
//  in_chan  sink       valid/ready        operation, grain_index, char_position,
//                                         byte_value, last_byte
//  out_chan source     valid/ready        grain_found
//  cfg_*    sink       cfg_we, no ready   cfg_index, cfg_wdata
//
// One word is taken per cycle while in_chan.ready is high. A text word is
// registered into the compare stage when taken, and its verdict, on the
// last byte only, is registered into the result register when that stage
// moves on. The result register is the only stall point: in_chan.ready
// drops only while a last-byte word waits behind an unread verdict. Reset
// is synchronous, and the grain store needs no clearing pass.
`include "multi_grain_substring_prefilter_core_defines.svh"

module multi_grain_substring_prefilter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  mgsp_in_if.sink                     in_chan,
  mgsp_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [mgsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mgsp_pkg::CFG_W-1:0]  cfg_wdata
);
  import mgsp_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] cnt_r, len_r;
  logic             anc_start_r, anc_end_r;
  scan_cfg_t        scfg;

  // Window and scan state.
  window_t           win_r, win_src, win_nxt;
  logic [SEEN_W-1:0] seen_r, seen_src, seen_nxt;
  logic              clr_r;
  logic              match_r, match_nxt;

  // Compare stage and result register.
  logic s1_vld_r, s1_vld_nxt, s1_last_r;
  logic s1_go;
  logic out_vld_r, out_vld_nxt, out_found_r, out_found_nxt;

  logic accept, text_acc, load_en;
  logic any_hit, allowed, hit;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      len_r       <= CFG_W'(GRAIN_LENGTH_MIN);
      anc_start_r <= 1'b0;
      anc_end_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAIN_COUNT:  cnt_r       <= cfg_wdata;
        REG_GRAIN_LENGTH: len_r       <= cfg_wdata;
        REG_ANCHOR_START: anc_start_r <= cfg_wdata[0];
        REG_ANCHOR_END:   anc_end_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp count and length into the supported range.
  always_comb begin
    scfg.count = (cnt_r > CFG_W'(GRAIN_COUNT_MAX)) ? CNT_W'(GRAIN_COUNT_MAX)
                                                    : CNT_W'(cnt_r);
    if (len_r < CFG_W'(GRAIN_LENGTH_MIN)) begin
      scfg.length = LEN_W'(GRAIN_LENGTH_MIN);
    end else if (len_r > CFG_W'(GRAIN_LENGTH_MAX)) begin
      scfg.length = LEN_W'(GRAIN_LENGTH_MAX);
    end else begin
      scfg.length = LEN_W'(len_r);
    end
  end

  // Handshake: the compare stage moves unless its verdict cannot be placed.
  assign s1_go          = !s1_vld_r || !s1_last_r || !out_vld_r || out_chan.ready;
  assign in_chan.ready  = s1_go;
  assign accept         = in_chan.valid && s1_go;
  assign text_acc       = accept && (in_chan.operation == OP_TEXT);
  assign load_en        = accept && (in_chan.operation == OP_LOAD)
                          && (32'(in_chan.grain_index) < GRAIN_COUNT_MAX)
                          && (32'(in_chan.char_position) < GRAIN_LENGTH_MAX);

  // A string that just ended leaves the window logically cleared.
  always_comb begin
    win_src  = clr_r ? '0 : win_r;
    seen_src = clr_r ? '0 : seen_r;
    win_nxt  = {win_src[GRAIN_LENGTH_MAX-2:0], in_chan.byte_value};
    seen_nxt = (seen_src >= SEEN_W'(SEEN_SAT)) ? SEEN_W'(SEEN_SAT)
                                               : seen_src + SEEN_W'(1);
  end

  // Window shift on every text word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      clr_r  <= 1'b1;
    end else if (text_acc) begin
      seen_r <= seen_nxt;
      clr_r  <= in_chan.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      win_r     <= win_nxt;
      s1_last_r <= in_chan.last_byte;
    end
  end

  mgsp_grain_store u_store (
    .clk      (clk),
    .wr_en    (load_en),
    .wr_grain (in_chan.grain_index[GI_W-1:0]),
    .wr_pos   (in_chan.char_position[CP_W-1:0]),
    .wr_byte  (in_chan.byte_value),
    .window   (win_r),
    .scfg     (scfg),
    .any_hit  (any_hit)
  );

  // Verdict of the word in the compare stage.
  always_comb begin
    if (anc_end_r) begin
      allowed = s1_last_r;
    end else if (anc_start_r) begin
      allowed = (seen_r == SEEN_W'(scfg.length));
    end else begin
      allowed = 1'b1;
    end
    hit = (seen_r >= SEEN_W'(scfg.length)) && any_hit;
  end

  // Stage valid, match flag and result register.
  always_comb begin
    s1_vld_nxt    = text_acc || (s1_vld_r && !s1_go);
    match_nxt     = match_r;
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    out_found_nxt = out_found_r;
    if (s1_vld_r && s1_go) begin
      match_nxt = s1_last_r ? 1'b0 : (match_r || (allowed && hit));
      if (s1_last_r) begin
        out_vld_nxt   = 1'b1;
        out_found_nxt = (scfg.count == '0) || match_r || (allowed && hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      match_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      match_r   <= match_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.grain_found = out_found_r;

  // Checks on the stage control.
  `MGSP_ASSERT_NOW(a_stall_blocks_in, s1_vld_r && s1_last_r && out_vld_r && !out_chan.ready, !in_chan.ready)
  `MGSP_ASSERT_NOW(a_seen_bounded, 1'b1, seen_r <= SEEN_W'(SEEN_SAT))
  `MGSP_ASSERT_NEXT(a_match_clears, s1_vld_r && s1_last_r && s1_go, !match_r && out_vld_r)
  `MGSP_ASSERT_NEXT(a_off_passes, s1_vld_r && s1_last_r && s1_go && (scfg.count == '0), out_chan.grain_found)

endmodule
